### hdl/int4_weight_matvec_row_dot_unit_macros.svh
// assertion macros shared by the queue and back end modules of the row dot unit
`ifndef INT4_WEIGHT_MATVEC_ROW_DOT_UNIT_MACROS_SVH
`define INT4_WEIGHT_MATVEC_ROW_DOT_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
// property must hold at every clock edge out of reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// condition must never be seen out of reset
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

### hdl/iwmv_pkg.sv
// types, constants and the saturating add of the row dot unit
package iwmv_pkg;

  localparam logic [3:0]        NIB_MASK   = 4'hF;
  localparam logic signed [4:0] NIB_OFFSET = 5'sd8;
  localparam int                ACC_W      = 32;
  localparam int                PROD_W     = 20;
  localparam int                ACT_W      = 16;
  localparam int                RES_W      = 48;

  // one queue entry: both products of an item plus the row end data
  typedef struct packed {
    logic signed [PROD_W-1:0] prod_lo;
    logic signed [PROD_W-1:0] prod_hi;
    logic signed [ACT_W-1:0]  row_scale;
    logic                     row_end;
  } entry_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] sum;
    logic                    ovf;
  } sat_t;

  // add one product to the accumulator, clamping to the 32-bit range
  function automatic sat_t sat_add(logic signed [ACC_W-1:0] acc,
                                   logic signed [PROD_W-1:0] prod);
    logic signed [ACC_W:0] wide;
    sat_t                  res;
    wide = {acc[ACC_W-1], acc} + (ACC_W+1)'(prod);
    res.ovf = (wide[ACC_W] != wide[ACC_W-1]);
    if (!res.ovf) begin
      res.sum = wide[ACC_W-1:0];
    end else if (wide[ACC_W]) begin
      res.sum = {1'b1, {(ACC_W-1){1'b0}}};
    end else begin
      res.sum = {1'b0, {(ACC_W-1){1'b1}}};
    end
    return res;
  endfunction

endpackage

### hdl/iwmv_in_if.sv
// input channel: one packed weight byte with its activations
interface iwmv_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  weight_byte;
  logic signed [15:0] act_low;
  logic signed [15:0] act_high;
  logic        high_valid;
  logic signed [15:0] row_scale;
  logic        row_end;

  modport source (output valid, weight_byte, act_low, act_high, high_valid,
                  row_scale, row_end, input ready);
  modport sink (input valid, weight_byte, act_low, act_high, high_valid,
                row_scale, row_end, output ready);
endinterface

### hdl/iwmv_out_if.sv
// result channel: scaled row sum and saturation flag
interface iwmv_out_if;
  logic        valid;
  logic        ready;
  logic signed [47:0] row_result;
  logic        row_saturated;

  modport source (output valid, row_result, row_saturated, input ready);
  modport sink (input valid, row_result, row_saturated, output ready);
endinterface

### hdl/iwmv_front.sv
// front end: accepts items, unpacks nibbles and forms both products
module iwmv_front (
  iwmv_in_if.sink         in_ch,
  input  logic            q_full,
  output logic            push,
  output iwmv_pkg::entry_t push_data
);

  logic [3:0]        nib_lo;
  logic [3:0]        nib_hi;
  logic signed [4:0] w_lo;
  logic signed [4:0] w_hi;
  logic signed [iwmv_pkg::PROD_W-1:0] p_lo;
  logic signed [iwmv_pkg::PROD_W-1:0] p_hi;

  // handshake: take an item whenever the queue has room
  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && !q_full;

  // offset binary nibbles to signed weights
  assign nib_lo = in_ch.weight_byte[3:0] & iwmv_pkg::NIB_MASK;
  assign nib_hi = in_ch.weight_byte[7:4] & iwmv_pkg::NIB_MASK;
  assign w_lo   = signed'({1'b0, nib_lo}) - iwmv_pkg::NIB_OFFSET;
  assign w_hi   = signed'({1'b0, nib_hi}) - iwmv_pkg::NIB_OFFSET;

  // narrow products, high one dropped on an odd tail
  assign p_lo = iwmv_pkg::PROD_W'(w_lo) * iwmv_pkg::PROD_W'(in_ch.act_low);
  assign p_hi = in_ch.high_valid ?
                iwmv_pkg::PROD_W'(w_hi) * iwmv_pkg::PROD_W'(in_ch.act_high) :
                '0;

  always_comb begin
    push_data.prod_lo   = p_lo;
    push_data.prod_hi   = p_hi;
    push_data.row_scale = in_ch.row_scale;
    push_data.row_end   = in_ch.row_end;
  end

endmodule

### hdl/iwmv_queue.sv
// short queue between the front and back ends
`include "int4_weight_matvec_row_dot_unit_macros.svh"
module iwmv_queue #(
  parameter int QDEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  iwmv_pkg::entry_t push_data,
  output logic             full,
  input  logic             pop,
  output logic             q_valid,
  output iwmv_pkg::entry_t q_data
);

  localparam int PTR_W = $clog2(QDEPTH);
  localparam int CNT_W = $clog2(QDEPTH + 1);

  iwmv_pkg::entry_t mem [QDEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full    = (count_r == CNT_W'(QDEPTH));
  assign q_valid = (count_r != '0);
  assign q_data  = mem[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  `ASSERT_NEVER(a_q_overfill, count_r > CNT_W'(QDEPTH), "queue count above depth")
  `ASSERT_NEVER(a_q_pop_empty, pop && (count_r == '0), "pop from empty queue")
  `ASSERT_CLK(a_q_count_track, (push && !pop) |=> (count_r == $past(count_r) + 1'b1), "queue count lost a push")

endmodule

### hdl/iwmv_back.sv
// back end: saturating accumulate, row scaling and result register
`include "int4_weight_matvec_row_dot_unit_macros.svh"
module iwmv_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  iwmv_pkg::entry_t q_data,
  output logic             pop,
  iwmv_out_if.source       out_ch
);

  localparam int ACC_W = iwmv_pkg::ACC_W;
  localparam int RES_W = iwmv_pkg::RES_W;

  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic                    ovf_r, ovf_nxt;
  iwmv_pkg::sat_t          s_lo;
  iwmv_pkg::sat_t          s_hi;

  logic                          mul_valid_r, mul_valid_nxt;
  logic signed [ACC_W-1:0]       mul_acc_r;
  logic signed [iwmv_pkg::ACT_W-1:0] mul_scale_r;
  logic                          mul_sat_r;
  logic                          mul_adv;

  logic                    out_valid_r, out_valid_nxt;
  logic signed [RES_W-1:0] out_result_r;
  logic                    out_sat_r;

  // the scale stage moves on when the result register is free
  assign mul_adv = mul_valid_r && (!out_valid_r || out_ch.ready);

  // a row end entry waits for the scale stage, others never wait
  assign pop = q_valid && (!q_data.row_end || !mul_valid_r || mul_adv);

  // low product first, then high
  assign s_lo = iwmv_pkg::sat_add(acc_r, q_data.prod_lo);
  assign s_hi = iwmv_pkg::sat_add(s_lo.sum, q_data.prod_hi);

  // accumulator and flag, cleared after the row end entry
  always_comb begin
    acc_nxt = acc_r;
    ovf_nxt = ovf_r;
    if (pop) begin
      if (q_data.row_end) begin
        acc_nxt = '0;
        ovf_nxt = 1'b0;
      end else begin
        acc_nxt = s_hi.sum;
        ovf_nxt = ovf_r || s_lo.ovf || s_hi.ovf;
      end
    end
  end

  // valid flags of the scale stage and result register
  always_comb begin
    mul_valid_nxt = (mul_valid_r && !mul_adv) || (pop && q_data.row_end);
    out_valid_nxt = mul_adv || (out_valid_r && !out_ch.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      ovf_r       <= 1'b0;
      mul_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      acc_r       <= acc_nxt;
      ovf_r       <= ovf_nxt;
      mul_valid_r <= mul_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload of the scale stage
  always_ff @(posedge clk) begin
    if (pop && q_data.row_end) begin
      mul_acc_r   <= s_hi.sum;
      mul_scale_r <= q_data.row_scale;
      mul_sat_r   <= ovf_r || s_lo.ovf || s_hi.ovf;
    end
  end

  // 32x16 product into the result register
  always_ff @(posedge clk) begin
    if (mul_adv) begin
      out_result_r <= RES_W'(mul_acc_r) * RES_W'(mul_scale_r);
      out_sat_r    <= mul_sat_r;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.row_result    = out_result_r;
  assign out_ch.row_saturated = out_sat_r;

  `ASSERT_CLK(a_row_clear, (pop && q_data.row_end) |=> ((acc_r == '0) && !ovf_r), "row end did not clear accumulator")
  `ASSERT_CLK(a_mul_hold, (mul_valid_r && !mul_adv) |=> mul_valid_r, "scale stage dropped a row")
  `ASSERT_NEVER(a_row_end_blocked, pop && q_data.row_end && mul_valid_r && !mul_adv, "row end overwrote busy scale stage")

endmodule

### hdl/int4_weight_matvec_row_dot_unit.sv
// top level of the 4-bit weight row dot product unit
//
//  channel  dir  handshake          payload
//  in_ch    in   valid / ready      weight_byte, act_low, act_high, high_valid,
//                                   row_scale, row_end
//  out_ch   out  valid / ready      row_result, row_saturated
//
// one item is taken per cycle while the queue has room; the two nibble
// products are formed on entry and summed into the accumulator as the item
// leaves the queue, one item per cycle while no row end item waits for the
// scale stage. a row result passes from its row end item through the scale
// stage register and the 32x16 multiplier into the result register.
// reset is synchronous and clears the accumulator, queue and valid flags.
// a stalled result holds its register and the next row end waits in the scale
// stage; items keep flowing in until a third row end reaches the queue head
// and the queue fills behind it.
module int4_weight_matvec_row_dot_unit #(
  parameter int QDEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  iwmv_in_if.sink    in_ch,
  iwmv_out_if.source out_ch
);

  logic             push;
  logic             q_full;
  logic             pop;
  logic             q_valid;
  iwmv_pkg::entry_t push_data;
  iwmv_pkg::entry_t q_data;

  // front end: unpack and multiply
  iwmv_front u_front (
    .in_ch     (in_ch),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  // decoupling queue
  iwmv_queue #(
    .QDEPTH (QDEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_data    (q_data)
  );

  // back end: accumulate and scale
  iwmv_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_data  (q_data),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule
